### src/knn_pkg.sv
`default_nettype none

package knn_pkg;

	localparam int MAX_K          = 16;
	localparam int COORD_BITS     = 16;
	localparam int INDEX_BITS     = 20;

	localparam int DIST_OUT_BITS  = 34;
	localparam int RANK_BITS      = 4;
	localparam int QCOORD_BITS    = 16;
	localparam int QINDEX_BITS    = 20;
	localparam int K_CFG_BITS     = 5;
	localparam int CFG_DATA_BITS  = 20;
	localparam int CFG_INDEX_BITS = 3;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_QUERY_X     = 3'd0,
		CFG_QUERY_Y     = 3'd1,
		CFG_QUERY_Z     = 3'd2,
		CFG_QUERY_INDEX = 3'd3,
		CFG_SKIP_SELF   = 3'd4,
		CFG_K_USED      = 3'd5
	} cfg_reg_t;

	// Flags that travel with a candidate down the distance pipeline.
	typedef struct packed {
		logic valid;
		logic ins;
		logic clr;
		logic emit;
	} knn_ctl_t;

endpackage

`default_nettype wire

### src/knn_if.sv
`default_nettype none

interface knn_cand_if #(
	parameter int COORD_BITS = knn_pkg::COORD_BITS,
	parameter int INDEX_BITS = knn_pkg::INDEX_BITS
) ();
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] cand_x;
	logic [COORD_BITS-1:0] cand_y;
	logic [COORD_BITS-1:0] cand_z;
	logic [INDEX_BITS-1:0] cand_index;
	logic                  clear_first;
	logic                  last_candidate;

	modport source (
		output valid, cand_x, cand_y, cand_z, cand_index, clear_first, last_candidate,
		input  ready
	);
	modport sink (
		input  valid, cand_x, cand_y, cand_z, cand_index, clear_first, last_candidate,
		output ready
	);
endinterface

interface knn_nbr_if #(
	parameter int INDEX_BITS = knn_pkg::INDEX_BITS
) ();
	logic                               valid;
	logic                               ready;
	logic [knn_pkg::RANK_BITS-1:0]      rank;
	logic [knn_pkg::DIST_OUT_BITS-1:0]  distance_sq;
	logic [INDEX_BITS-1:0]              neighbor_index;
	logic                               entry_valid;
	logic                               last;

	modport source (
		output valid, rank, distance_sq, neighbor_index, entry_valid, last,
		input  ready
	);
	modport sink (
		input  valid, rank, distance_sq, neighbor_index, entry_valid, last,
		output ready
	);
endinterface

`default_nettype wire

### src/knn_dist.sv
`default_nettype none

module knn_dist #(
	parameter int COORD_BITS = knn_pkg::COORD_BITS,
	parameter int INDEX_BITS = knn_pkg::INDEX_BITS,
	parameter int DIST_BITS  = 2 * COORD_BITS + 2
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  knn_pkg::knn_ctl_t     in_ctl,
	input  wire  [COORD_BITS-1:0] cx,
	input  wire  [COORD_BITS-1:0] cy,
	input  wire  [COORD_BITS-1:0] cz,
	input  wire  [INDEX_BITS-1:0] cidx,
	input  wire  [COORD_BITS-1:0] qx,
	input  wire  [COORD_BITS-1:0] qy,
	input  wire  [COORD_BITS-1:0] qz,
	output knn_pkg::knn_ctl_t     out_ctl,
	output logic [DIST_BITS-1:0]  out_dist,
	output logic [INDEX_BITS-1:0] out_idx
);

	localparam int SQ_BITS = 2 * COORD_BITS;

	knn_pkg::knn_ctl_t     ctl_s1, ctl_s2, ctl_s3;
	logic [COORD_BITS-1:0] dx_s1, dy_s1, dz_s1;
	logic [INDEX_BITS-1:0] idx_s1, idx_s2, idx_s3;
	logic [SQ_BITS-1:0]    sqx_s2, sqy_s2, sqz_s2;
	logic [DIST_BITS-1:0]  dist_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s1 <= in_ctl;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1   <= (cx >= qx) ? cx - qx : qx - cx;
		dy_s1   <= (cy >= qy) ? cy - qy : qy - cy;
		dz_s1   <= (cz >= qz) ? cz - qz : qz - cz;
		idx_s1  <= cidx;
		sqx_s2  <= SQ_BITS'(dx_s1) * SQ_BITS'(dx_s1);
		sqy_s2  <= SQ_BITS'(dy_s1) * SQ_BITS'(dy_s1);
		sqz_s2  <= SQ_BITS'(dz_s1) * SQ_BITS'(dz_s1);
		idx_s2  <= idx_s1;
		dist_s3 <= DIST_BITS'(sqx_s2) + DIST_BITS'(sqy_s2) + DIST_BITS'(sqz_s2);
		idx_s3  <= idx_s2;
	end

	assign out_ctl  = ctl_s3;
	assign out_dist = dist_s3;
	assign out_idx  = idx_s3;

endmodule

`default_nettype wire

### src/knn_cell.sv
`default_nettype none

module knn_cell #(
	parameter int DIST_BITS  = 2 * knn_pkg::COORD_BITS + 2,
	parameter int INDEX_BITS = knn_pkg::INDEX_BITS
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  knn_pkg::knn_ctl_t     ctl,
	input  wire                   in_range,
	input  wire  [DIST_BITS-1:0]  new_dist,
	input  wire  [INDEX_BITS-1:0] new_idx,
	input  wire                   left_g,
	input  wire  [DIST_BITS-1:0]  left_dist,
	input  wire  [INDEX_BITS-1:0] left_idx,
	input  wire                   left_valid,
	output logic                  g,
	output logic [DIST_BITS-1:0]  ent_dist,
	output logic [INDEX_BITS-1:0] idx,
	output logic                  valid
);

	logic                  valid_q;
	logic [DIST_BITS-1:0]  dist_q;
	logic [INDEX_BITS-1:0] idx_q;
	logic                  ins;
	logic                  clr;

	assign ins = ctl.valid && ctl.ins && in_range;
	assign clr = ctl.valid && ctl.clr;

	// The candidate goes in front of this entry. A clear in the same beat
	// empties the entry first, and an equal distance stays behind it.
	assign g = clr || !valid_q || (dist_q > new_dist);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			if (ins) begin
				priority if (left_g) begin
					valid_q <= left_valid;
				end else if (g) begin
					valid_q <= 1'b1;
				end else begin
					valid_q <= valid_q && !clr;
				end
			end else if (clr) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ins) begin
			priority if (left_g) begin
				dist_q <= left_dist;
				idx_q  <= left_idx;
			end else if (g) begin
				dist_q <= new_dist;
				idx_q  <= new_idx;
			end else begin
				dist_q <= dist_q;
				idx_q  <= idx_q;
			end
		end
	end

	assign ent_dist = dist_q;
	assign idx      = idx_q;
	// The right neighbor sees this entry as it stands after a clear.
	assign valid    = valid_q && !clr;

endmodule

`default_nettype wire

### src/knn_sorted_topk_insert_top.sv
`default_nettype none

// Sorted k-nearest list for one query point. A candidate beat is taken in
// every cycle while no emission is pending; it passes through the distance
// pipeline (absolute differences, squares, sum) and is then inserted by the
// row of MAX_K cells, each of which compares its own entry with the new
// distance and either keeps it, takes the new one or takes its left
// neighbor's. A beat with last_candidate set closes the input from its
// acceptance until the last of the k result beats is loaded into the output
// register; the list is read out at one entry per cycle while the output is
// not stalled. Reset empties the list at once; there is no clearing pass.
module knn_sorted_topk_insert_top #(
	parameter int MAX_K      = knn_pkg::MAX_K,
	parameter int COORD_BITS = knn_pkg::COORD_BITS,
	parameter int INDEX_BITS = knn_pkg::INDEX_BITS
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_we,
	input  wire  [knn_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  wire  [knn_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	knn_cand_if.sink                             cand,
	knn_nbr_if.source                            nbr
);

	localparam int DIST_BITS = 2 * COORD_BITS + 2;
	localparam int IW        = (MAX_K > 1) ? $clog2(MAX_K) : 1;
	localparam int KW        = $clog2(MAX_K + 1);
	localparam int QC        = knn_pkg::QCOORD_BITS;
	localparam int QI        = knn_pkg::QINDEX_BITS;
	localparam int KC        = knn_pkg::K_CFG_BITS;
	localparam int RB        = knn_pkg::RANK_BITS;
	localparam int DO        = knn_pkg::DIST_OUT_BITS;

	logic [QC-1:0] query_x_q, query_y_q, query_z_q;
	logic [QI-1:0] query_index_q;
	logic          skip_self_q;
	logic [KC-1:0] k_used_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_x_q     <= '0;
			query_y_q     <= '0;
			query_z_q     <= '0;
			query_index_q <= '0;
			skip_self_q   <= 1'b0;
			k_used_q      <= KC'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				knn_pkg::CFG_QUERY_X:     query_x_q     <= QC'(cfg_data);
				knn_pkg::CFG_QUERY_Y:     query_y_q     <= QC'(cfg_data);
				knn_pkg::CFG_QUERY_Z:     query_z_q     <= QC'(cfg_data);
				knn_pkg::CFG_QUERY_INDEX: query_index_q <= QI'(cfg_data);
				knn_pkg::CFG_SKIP_SELF:   skip_self_q   <= cfg_data[0];
				knn_pkg::CFG_K_USED:      k_used_q      <= KC'(cfg_data);
				default: ;
			endcase
		end
	end

	logic [KW-1:0] k_act;

	always_comb begin
		priority if (k_used_q == '0) begin
			k_act = KW'(1);
		end else if (int'(k_used_q) > MAX_K) begin
			k_act = KW'(MAX_K);
		end else begin
			k_act = KW'(k_used_q);
		end
	end

	// Input side.
	logic              busy_q;
	logic              in_acc;
	logic              skip;
	knn_pkg::knn_ctl_t in_ctl;

	assign cand.ready = !busy_q;
	assign in_acc     = cand.valid && cand.ready;
	assign skip       = skip_self_q && (cand.cand_index == INDEX_BITS'(query_index_q));

	always_comb begin
		in_ctl.valid = in_acc;
		in_ctl.ins   = !skip;
		in_ctl.clr   = cand.clear_first;
		in_ctl.emit  = cand.last_candidate;
	end

	knn_pkg::knn_ctl_t      d_ctl;
	logic [DIST_BITS-1:0]   d_dist;
	logic [INDEX_BITS-1:0]  d_idx;

	knn_dist #(
		.COORD_BITS (COORD_BITS),
		.INDEX_BITS (INDEX_BITS),
		.DIST_BITS  (DIST_BITS)
	) u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ctl   (in_ctl),
		.cx       (cand.cand_x),
		.cy       (cand.cand_y),
		.cz       (cand.cand_z),
		.cidx     (cand.cand_index),
		.qx       (COORD_BITS'(query_x_q)),
		.qy       (COORD_BITS'(query_y_q)),
		.qz       (COORD_BITS'(query_z_q)),
		.out_ctl  (d_ctl),
		.out_dist (d_dist),
		.out_idx  (d_idx)
	);

	// Row of cells, position 0 nearest.
	logic                  cell_g     [MAX_K];
	logic [DIST_BITS-1:0]  cell_dist  [MAX_K];
	logic [INDEX_BITS-1:0] cell_idx   [MAX_K];
	logic                  cell_valid [MAX_K];

	for (genvar i = 0; i < MAX_K; i++) begin : g_cell
		logic                  lg;
		logic [DIST_BITS-1:0]  ld;
		logic [INDEX_BITS-1:0] li;
		logic                  lv;

		if (i == 0) begin : g_head
			assign lg = 1'b0;
			assign ld = '0;
			assign li = '0;
			assign lv = 1'b0;
		end else begin : g_body
			assign lg = cell_g[i-1];
			assign ld = cell_dist[i-1];
			assign li = cell_idx[i-1];
			assign lv = cell_valid[i-1];
		end

		knn_cell #(
			.DIST_BITS  (DIST_BITS),
			.INDEX_BITS (INDEX_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (d_ctl),
			.in_range   (KW'(i) < k_act),
			.new_dist   (d_dist),
			.new_idx    (d_idx),
			.left_g     (lg),
			.left_dist  (ld),
			.left_idx   (li),
			.left_valid (lv),
			.g          (cell_g[i]),
			.ent_dist   (cell_dist[i]),
			.idx        (cell_idx[i]),
			.valid      (cell_valid[i])
		);
	end

	// Read-out of the list and output register.
	logic                  emit_on_q;
	logic [IW-1:0]         emit_cnt_q;
	logic                  load;
	logic                  at_end;
	logic                  out_valid_q;
	logic [RB-1:0]         rank_q;
	logic [DO-1:0]         dist_q;
	logic [INDEX_BITS-1:0] nidx_q;
	logic                  evalid_q;
	logic                  last_q;

	assign load   = emit_on_q && (!out_valid_q || nbr.ready);
	assign at_end = KW'(emit_cnt_q) == (k_act - KW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			emit_on_q   <= 1'b0;
			emit_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc && cand.last_candidate) begin
				busy_q <= 1'b1;
			end
			if (d_ctl.valid && d_ctl.emit) begin
				emit_on_q  <= 1'b1;
				emit_cnt_q <= '0;
			end else if (load) begin
				if (at_end) begin
					emit_on_q <= 1'b0;
					busy_q    <= 1'b0;
				end else begin
					emit_cnt_q <= emit_cnt_q + IW'(1);
				end
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (nbr.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rank_q   <= RB'(emit_cnt_q);
			evalid_q <= cell_valid[emit_cnt_q];
			dist_q   <= cell_valid[emit_cnt_q] ? DO'(cell_dist[emit_cnt_q]) : '0;
			nidx_q   <= cell_valid[emit_cnt_q] ? cell_idx[emit_cnt_q] : '0;
			last_q   <= at_end;
		end
	end

	assign nbr.valid          = out_valid_q;
	assign nbr.rank           = rank_q;
	assign nbr.distance_sq    = dist_q;
	assign nbr.neighbor_index = nidx_q;
	assign nbr.entry_valid    = evalid_q;
	assign nbr.last           = last_q;

endmodule

`default_nettype wire

### src/knn_chk.sv
`default_nettype none

module knn_chk #(
	parameter int INDEX_BITS = knn_pkg::INDEX_BITS
) (
	input wire                              clk,
	input wire                              arst_n,
	input wire                              in_ready,
	input wire                              out_valid,
	input wire                              out_ready,
	input wire [knn_pkg::RANK_BITS-1:0]     out_rank,
	input wire [knn_pkg::DIST_OUT_BITS-1:0] out_dist,
	input wire [INDEX_BITS-1:0]             out_nidx,
	input wire                              out_evalid,
	input wire                              out_last
);

	localparam int RB = knn_pkg::RANK_BITS;

	// A stalled result beat keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_rank) && $stable(out_dist)
			&& $stable(out_nidx) && $stable(out_evalid) && $stable(out_last))
		else $error("result beat changed while stalled");

	// Within a list the beats follow without gaps and the rank counts up.
	a_rank_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last |=>
			out_valid && (out_rank == RB'($past(out_rank) + RB'(1))))
		else $error("list beats not contiguous");

	// No candidate is taken while a list is still being read out.
	a_no_in_mid_list: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_last |-> !in_ready)
		else $error("input open during list read-out");

	// An empty entry carries zero payload.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_evalid |-> (out_dist == '0) && (out_nidx == '0))
		else $error("empty entry with nonzero payload");

endmodule

bind knn_sorted_topk_insert_top knn_chk #(
	.INDEX_BITS (INDEX_BITS)
) u_knn_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (cand.ready),
	.out_valid  (nbr.valid),
	.out_ready  (nbr.ready),
	.out_rank   (nbr.rank),
	.out_dist   (nbr.distance_sq),
	.out_nidx   (nbr.neighbor_index),
	.out_evalid (nbr.entry_valid),
	.out_last   (nbr.last)
);

`default_nettype wire
